### hdl/rrs_pkg.sv
`timescale 1ns / 1ps

package rrs_pkg;

  // Default table size: idle slot plus three tasks
  localparam int SLOTS_DEF = 4;

  // Command codes carried by the input word
  typedef enum logic [1:0] {
    CMD_SCHED  = 2'd0,
    CMD_SLEEP  = 2'd1,
    CMD_EXIT   = 2'd2,
    CMD_CREATE = 2'd3
  } cmd_t;

  // Per-slot task state
  typedef enum logic [1:0] {
    ST_RUNNING  = 2'd0,
    ST_READY    = 2'd1,
    ST_SLEEPING = 2'd2,
    ST_DEAD     = 2'd3
  } slot_st_t;

  // Create status codes reported in the result word
  typedef enum logic [1:0] {
    CS_NONE    = 2'd0,
    CS_CREATED = 2'd1,
    CS_FULL    = 2'd2
  } cstat_t;

  // How the slot cursor moves
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_FIRST,
    IDX_RUN,
    IDX_NEXT,
    IDX_RR,
    IDX_RR_RUN,
    IDX_APP
  } idx_op_t;

  // Controller to datapath
  typedef struct packed {
    logic     capture;
    idx_op_t  idx_op;
    logic     cnt_clr;
    logic     cnt_inc;
    logic     st_we;
    slot_st_t st_val;
    logic     wk_we;
    logic     wk_add;
    logic     run_commit;
    logic     hu_inc;
    logic     cslot_set;
    logic     out_load;
    logic     out_switched;
    cstat_t   out_cstat;
    logic     out_no_ready;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic rd_dead;
    logic rd_sleeping;
    logic rd_due;
    logic idx_at_hu;
    logic hu_zero;
    logic hu_full;
    logic cnt_at_hu;
  } dp_stat_t;

endpackage

### hdl/rrs_if.sv
`timescale 1ns / 1ps

// Command word channel
interface rrs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] current_time;
  logic [31:0] sleep_seconds;

  modport source (output valid, command, current_time, sleep_seconds, input ready);
  modport sink   (input valid, command, current_time, sleep_seconds, output ready);
endinterface

// Result word channel
interface rrs_out_if import rrs_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
);
  localparam int IDX_W = $clog2(SLOTS);

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] running_slot;
  logic [IDX_W-1:0] previous_slot;
  logic             switched;
  logic [1:0]       create_status;
  logic [IDX_W-1:0] created_slot;
  logic             no_ready;

  modport source (output valid, running_slot, previous_slot, switched, create_status,
                  created_slot, no_ready, input ready);
  modport sink   (input valid, running_slot, previous_slot, switched, create_status,
                  created_slot, no_ready, output ready);
endinterface

### hdl/rrs_datapath.sv
`timescale 1ns / 1ps

module rrs_datapath import rrs_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_cmd_t                    cmd,
  output dp_stat_t                   stat,
  input  logic [1:0]                 in_command,
  input  logic [31:0]                in_current_time,
  input  logic [31:0]                in_sleep_seconds,
  output logic [$clog2(SLOTS)-1:0]   out_running_slot,
  output logic [$clog2(SLOTS)-1:0]   out_previous_slot,
  output logic                       out_switched,
  output logic [1:0]                 out_create_status,
  output logic [$clog2(SLOTS)-1:0]   out_created_slot,
  output logic                       out_no_ready
);

  localparam int IDX_W = $clog2(SLOTS);

  // Captured command word
  cmd_t        cmd_r;
  logic [31:0] now_r;
  logic [31:0] secs_r;

  // Slot table: state and wake time, one read and one write port each
  slot_st_t    st_mem [SLOTS];
  logic [31:0] wk_mem [SLOTS];
  logic [SLOTS-1:0] st_vld_r;
  logic [SLOTS-1:0] wk_vld_r;

  slot_st_t    rd_st_raw_r;
  logic [31:0] rd_wk_raw_r;
  logic        rd_st_vld_r;
  logic        rd_wk_vld_r;
  logic        rd_idx0_r;
  slot_st_t    rd_st;
  logic [31:0] rd_wk;
  logic [31:0] wk_wdata;

  // Scheduler registers
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] cnt_r;
  logic [IDX_W-1:0] run_r;
  logic [IDX_W-1:0] prev_r;
  logic [IDX_W-1:0] hu_r;
  logic [IDX_W-1:0] cslot_r;

  function automatic logic [IDX_W-1:0] rr_next(input logic [IDX_W-1:0] x,
                                               input logic [IDX_W-1:0] top);
    logic [IDX_W-1:0] res;
    res = (x >= top) ? '0 : x + IDX_W'(1);
    return res;
  endfunction

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= cmd_t'(in_command);
      now_r  <= in_current_time;
      secs_r <= in_sleep_seconds;
    end
  end

  // Table memories; read data registered every cycle at the cursor
  always_ff @(posedge clk) begin
    if (cmd.st_we) begin
      st_mem[idx_r] <= cmd.st_val;
    end
    if (cmd.wk_we) begin
      wk_mem[idx_r] <= wk_wdata;
    end
    rd_st_raw_r <= st_mem[idx_r];
    rd_wk_raw_r <= wk_mem[idx_r];
  end

  // Written-entry flags; an unwritten entry reads as its reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= '0;
      wk_vld_r <= '0;
    end else begin
      if (cmd.st_we) begin
        st_vld_r[idx_r] <= 1'b1;
      end
      if (cmd.wk_we) begin
        wk_vld_r[idx_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_st_vld_r <= st_vld_r[idx_r];
    rd_wk_vld_r <= wk_vld_r[idx_r];
    rd_idx0_r   <= (idx_r == '0);
  end

  always_comb begin
    if (rd_st_vld_r) begin
      rd_st = rd_st_raw_r;
    end else if (rd_idx0_r) begin
      rd_st = ST_RUNNING;
    end else begin
      rd_st = ST_DEAD;
    end
    rd_wk    = rd_wk_vld_r ? rd_wk_raw_r : '0;
    // sleep adds to the old wake time (wraps); create stamps the present time
    wk_wdata = cmd.wk_add ? (rd_wk + secs_r) : now_r;
  end

  // Cursor and visit counter
  always_ff @(posedge clk) begin
    unique case (cmd.idx_op)
      IDX_HOLD:   idx_r <= idx_r;
      IDX_FIRST:  idx_r <= IDX_W'(1);
      IDX_RUN:    idx_r <= run_r;
      IDX_NEXT:   idx_r <= idx_r + IDX_W'(1);
      IDX_RR:     idx_r <= rr_next(idx_r, hu_r);
      IDX_RR_RUN: idx_r <= rr_next(run_r, hu_r);
      IDX_APP:    idx_r <= hu_r + IDX_W'(1);
      default:    idx_r <= idx_r;
    endcase
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + IDX_W'(1);
    end
  end

  // Running / previous / highest used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= '0;
      prev_r <= IDX_W'(1);
      hu_r   <= '0;
    end else begin
      if (cmd.run_commit) begin
        prev_r <= run_r;
        run_r  <= idx_r;
      end
      if (cmd.hu_inc) begin
        hu_r <= hu_r + IDX_W'(1);
      end
    end
  end

  // Created slot and result word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cslot_r <= '0;
    end else if (cmd.cslot_set) begin
      cslot_r <= idx_r;
    end
    if (cmd.out_load) begin
      out_running_slot  <= run_r;
      out_previous_slot <= prev_r;
      out_switched      <= cmd.out_switched;
      out_create_status <= cmd.out_cstat;
      out_created_slot  <= cslot_r;
      out_no_ready      <= cmd.out_no_ready;
    end
  end

  // Status back to the controller
  always_comb begin
    stat.cmd         = cmd_r;
    stat.rd_dead     = (rd_st == ST_DEAD);
    stat.rd_sleeping = (rd_st == ST_SLEEPING);
    stat.rd_due      = (rd_wk <= now_r);
    stat.idx_at_hu   = (idx_r == hu_r);
    stat.hu_zero     = (hu_r == '0);
    stat.hu_full     = (hu_r == IDX_W'(SLOTS - 1));
    stat.cnt_at_hu   = (cnt_r == hu_r);
  end

endmodule

### hdl/rrs_ctrl.sv
`timescale 1ns / 1ps

module rrs_ctrl import rrs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_C_RD,
    S_C_EV,
    S_C_APP,
    S_C_WR,
    S_K_RD,
    S_K_EV,
    S_W_BEGIN,
    S_W_RD,
    S_W_EV,
    S_S_BEGIN,
    S_S_RD,
    S_S_EV,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   sw_r, sw_nxt;
  cstat_t cst_r, cst_nxt;
  logic   nr_r, nr_nxt;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  // Sequencer: decode and next state
  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r;
    sw_nxt        = sw_r;
    cst_nxt       = cst_r;
    nr_nxt        = nr_r;
    cmd           = '0;
    cmd.idx_op    = IDX_HOLD;
    cmd.st_val    = ST_RUNNING;
    cmd.out_cstat = CS_NONE;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.capture  = 1'b1;
          in_ready_nxt = 1'b0;
          sw_nxt       = 1'b0;
          cst_nxt      = CS_NONE;
          nr_nxt       = 1'b0;
          state_nxt    = S_START;
        end
      end

      S_START: begin
        unique case (stat.cmd)
          CMD_CREATE: begin
            if (stat.hu_zero) begin
              state_nxt = S_C_APP;
            end else begin
              cmd.idx_op = IDX_FIRST;
              state_nxt  = S_C_RD;
            end
          end
          CMD_SLEEP, CMD_EXIT: begin
            cmd.idx_op = IDX_RUN;
            state_nxt  = S_K_RD;
          end
          CMD_SCHED: state_nxt = S_W_BEGIN;
          default:   state_nxt = S_W_BEGIN;
        endcase
      end

      // create: look for the lowest dead slot
      S_C_RD: state_nxt = S_C_EV;
      S_C_EV: begin
        if (stat.rd_dead) begin
          cmd.st_we     = 1'b1;
          cmd.st_val    = ST_READY;
          cmd.wk_we     = 1'b1;
          cmd.cslot_set = 1'b1;
          cst_nxt       = CS_CREATED;
          state_nxt     = S_DONE;
        end else if (stat.idx_at_hu) begin
          state_nxt = S_C_APP;
        end else begin
          cmd.idx_op = IDX_NEXT;
          state_nxt  = S_C_RD;
        end
      end
      S_C_APP: begin
        if (stat.hu_full) begin
          cst_nxt   = CS_FULL;
          state_nxt = S_DONE;
        end else begin
          cmd.hu_inc = 1'b1;
          cmd.idx_op = IDX_APP;
          state_nxt  = S_C_WR;
        end
      end
      S_C_WR: begin
        cmd.st_we     = 1'b1;
        cmd.st_val    = ST_READY;
        cmd.wk_we     = 1'b1;
        cmd.cslot_set = 1'b1;
        cst_nxt       = CS_CREATED;
        state_nxt     = S_DONE;
      end

      // sleep / exit on the running slot
      S_K_RD: state_nxt = S_K_EV;
      S_K_EV: begin
        cmd.st_we = 1'b1;
        if (stat.cmd == CMD_SLEEP) begin
          cmd.st_val = ST_SLEEPING;
          cmd.wk_we  = 1'b1;
          cmd.wk_add = 1'b1;
        end else begin
          cmd.st_val = ST_DEAD;
        end
        state_nxt = S_W_BEGIN;
      end

      // wake pass over slots 1..highest used
      S_W_BEGIN: begin
        if (stat.hu_zero) begin
          state_nxt = S_S_BEGIN;
        end else begin
          cmd.idx_op = IDX_FIRST;
          state_nxt  = S_W_RD;
        end
      end
      S_W_RD: state_nxt = S_W_EV;
      S_W_EV: begin
        if (stat.rd_due && !stat.rd_dead) begin
          cmd.st_we  = 1'b1;
          cmd.st_val = ST_READY;
        end
        if (stat.idx_at_hu) begin
          state_nxt = S_S_BEGIN;
        end else begin
          cmd.idx_op = IDX_NEXT;
          state_nxt  = S_W_RD;
        end
      end

      // round-robin pick after the running slot
      S_S_BEGIN: begin
        cmd.idx_op  = IDX_RR_RUN;
        cmd.cnt_clr = 1'b1;
        state_nxt   = S_S_RD;
      end
      S_S_RD: state_nxt = S_S_EV;
      S_S_EV: begin
        if (!stat.rd_sleeping && !stat.rd_dead) begin
          cmd.st_we      = 1'b1;
          cmd.st_val     = ST_RUNNING;
          cmd.run_commit = 1'b1;
          sw_nxt         = 1'b1;
          state_nxt      = S_DONE;
        end else if (stat.cnt_at_hu) begin
          nr_nxt    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          cmd.idx_op  = IDX_RR;
          cmd.cnt_inc = 1'b1;
          state_nxt   = S_S_RD;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load     = 1'b1;
          cmd.out_switched = sw_r;
          cmd.out_cstat    = cst_r;
          cmd.out_no_ready = nr_r;
          out_valid_nxt    = 1'b1;
          in_ready_nxt     = 1'b1;
          state_nxt        = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
      sw_r        <= 1'b0;
      cst_r       <= CS_NONE;
      nr_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
      sw_r        <= sw_nxt;
      cst_r       <= cst_nxt;
      nr_r        <= nr_nxt;
    end
  end

endmodule

### hdl/round_robin_task_scheduler.sv
`timescale 1ns / 1ps

// Round-robin task scheduler with sleep timers. Slot 0 is the idle task; up to
// SLOTS-1 tasks are created into the lowest dead slot or appended. Each command
// word (schedule, sleep, exit, create) gives exactly one result word. Words are
// handled one at a time by a sequencer walking the slot table through its single
// read port, each slot visit being an address step, then an evaluate/write back.
// A schedule runs a wake pass over slots 1 to the highest used slot, then a
// round-robin pick after the running slot; sleep and exit first write the
// running slot. A create probes for the lowest dead slot, then appends or
// reports the table full. in_ready rises together with the registered result,
// so the next word can be accepted even while that result is still waiting on
// out_bus.ready. The table needs no clearing pass after reset.

module round_robin_task_scheduler import rrs_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rrs_in_if.sink       in_bus,
  rrs_out_if.source    out_bus
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  rrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  rrs_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .stat              (dp_stat),
    .in_command        (in_bus.command),
    .in_current_time   (in_bus.current_time),
    .in_sleep_seconds  (in_bus.sleep_seconds),
    .out_running_slot  (out_bus.running_slot),
    .out_previous_slot (out_bus.previous_slot),
    .out_switched      (out_bus.switched),
    .out_create_status (out_bus.create_status),
    .out_created_slot  (out_bus.created_slot),
    .out_no_ready      (out_bus.no_ready)
  );

endmodule

### hdl/rrs_checker.sv
`timescale 1ns / 1ps

module rrs_checker import rrs_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [$clog2(SLOTS)-1:0] running_slot,
  input logic [$clog2(SLOTS)-1:0] previous_slot,
  input logic                     switched,
  input logic [1:0]               create_status,
  input logic [$clog2(SLOTS)-1:0] created_slot,
  input logic                     no_ready
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({running_slot, previous_slot, switched, create_status, created_slot, no_ready}))
    else $error("result word changed while stalled");

  // A reschedule either switches or finds nothing eligible, never both
  a_sw_nr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(switched && no_ready))
    else $error("switched and no_ready both set");

  // A create never reschedules
  a_create_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (create_status != CS_NONE) |-> !switched && !no_ready)
    else $error("create reported a reschedule");

  // Created slot is a task slot exactly when a task was created
  a_cslot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((create_status == CS_CREATED) == (created_slot != '0)) &&
      (create_status == CS_NONE || create_status == CS_CREATED || create_status == CS_FULL))
    else $error("create status and created slot disagree");

endmodule

bind round_robin_task_scheduler rrs_checker #(
  .SLOTS (SLOTS)
) u_rrs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .running_slot  (out_bus.running_slot),
  .previous_slot (out_bus.previous_slot),
  .switched      (out_bus.switched),
  .create_status (out_bus.create_status),
  .created_slot  (out_bus.created_slot),
  .no_ready      (out_bus.no_ready)
);

### tb/task_table_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the scheduler. Keeps its own copy of the task table.
// Each accepted command word queues one predicted result word. Each accepted
// result word is compared with the oldest prediction.
module task_table_checker import rrs_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               in_command,
  input  logic [31:0]              in_current_time,
  input  logic [31:0]              in_sleep_seconds,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [$clog2(SLOTS)-1:0] out_running_slot,
  input  logic [$clog2(SLOTS)-1:0] out_previous_slot,
  input  logic                     out_switched,
  input  logic [1:0]               out_create_status,
  input  logic [$clog2(SLOTS)-1:0] out_created_slot,
  input  logic                     out_no_ready,
  output int                       mismatch_count,
  output int                       results_owed
);

  localparam int IDX_W = $clog2(SLOTS);
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    idx_t   running;
    idx_t   previous;
    logic   switched;
    cstat_t cstat;
    idx_t   cslot;
    logic   no_ready;
  } sched_result_t;

  // Shadow task table
  slot_st_t      slot_st [SLOTS];
  logic [31:0]   wake_at [SLOTS];
  idx_t          run_idx;
  idx_t          prev_idx;
  idx_t          top_used;
  sched_result_t pending_results [$];
  int            fails = 0;

  assign mismatch_count = fails;

  function automatic void clear_task_table();
    for (int i = 0; i < SLOTS; i++) begin
      slot_st[i] = ST_DEAD;
      wake_at[i] = '0;
    end
    slot_st[0] = ST_RUNNING;
    run_idx    = '0;
    prev_idx   = idx_t'(1);
    top_used   = '0;
  endfunction

  // Wake due tasks, then walk round-robin to the next eligible slot.
  function automatic bit pick_next(logic [31:0] now);
    int cand;
    // idle slot is never woken
    for (int i = 1; i <= int'(top_used); i++) begin
      if (wake_at[i] <= now && slot_st[i] != ST_DEAD) slot_st[i] = ST_READY;
    end
    cand = int'(run_idx);
    for (int n = 0; n <= int'(top_used); n++) begin
      cand = (cand >= int'(top_used)) ? 0 : cand + 1;
      if (slot_st[cand] != ST_SLEEPING && slot_st[cand] != ST_DEAD) begin
        prev_idx      = run_idx;
        run_idx       = idx_t'(cand);
        slot_st[cand] = ST_RUNNING;
        return 1'b1;
      end
    end
    // nothing eligible: indexes and states stay as they are
    return 1'b0;
  endfunction

  // Apply one command word to the shadow table and give the expected result.
  function automatic sched_result_t advance_task_table(cmd_t cmd, logic [31:0] now,
                                                       logic [31:0] secs);
    sched_result_t r;
    int            pick;
    r    = '0;
    pick = 0;
    if (cmd == CMD_CREATE) begin
      // lowest dead slot first, else append
      for (int i = 1; i <= int'(top_used); i++) begin
        if (slot_st[i] == ST_DEAD) begin
          pick = i;
          break;
        end
      end
      if (pick == 0 && int'(top_used) + 1 < SLOTS) begin
        top_used = top_used + 1'b1;
        pick     = int'(top_used);
      end
      if (pick != 0) begin
        wake_at[pick] = now;
        slot_st[pick] = ST_READY;
        r.cstat       = CS_CREATED;
        r.cslot       = idx_t'(pick);
      end else begin
        r.cstat = CS_FULL;
      end
    end else begin
      if (cmd == CMD_SLEEP) begin
        wake_at[run_idx] = wake_at[run_idx] + secs;
        slot_st[run_idx] = ST_SLEEPING;
      end else if (cmd == CMD_EXIT) begin
        slot_st[run_idx] = ST_DEAD;
      end
      if (pick_next(now)) r.switched = 1'b1;
      else r.no_ready = 1'b1;
    end
    r.running  = run_idx;
    r.previous = prev_idx;
    return r;
  endfunction

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  // Result words are checked before the command word of the same edge is queued
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      clear_task_table();
      pending_results.delete();
      fails = 0;
      results_owed <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with none expected, expected nothing, actual running %0d",
                   $time, out_running_slot);
          fails++;
        end else begin
          want = pending_results.pop_front();
          report_field("running_slot", want.running, out_running_slot);
          report_field("previous_slot", want.previous, out_previous_slot);
          report_field("switched", want.switched, out_switched);
          report_field("create_status", want.cstat, out_create_status);
          report_field("created_slot", want.cslot, out_created_slot);
          report_field("no_ready", want.no_ready, out_no_ready);
        end
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(advance_task_table(cmd_t'(in_command), in_current_time,
                                                     in_sleep_seconds));
      end
      results_owed <= pending_results.size();
    end
  end

endmodule

### tb/tb_round_robin_task_scheduler.sv
`timescale 1ns / 1ps

module tb_round_robin_task_scheduler;
  import rrs_pkg::*;

  localparam int SLOTS        = SLOTS_DEF;
  localparam int RANDOM_WORDS = 1625;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int   mismatch_count;
  int   results_owed;
  int   cycles = 0;
  bit   feed_idle_on = 1'b1;
  bit   sink_idle_on = 1'b1;

  rrs_in_if                   in_bus ();
  rrs_out_if #(.SLOTS(SLOTS)) out_bus ();

  round_robin_task_scheduler #(.SLOTS(SLOTS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  task_table_checker #(.SLOTS(SLOTS)) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_bus.valid),
    .in_ready         (in_bus.ready),
    .in_command       (in_bus.command),
    .in_current_time  (in_bus.current_time),
    .in_sleep_seconds (in_bus.sleep_seconds),
    .out_valid        (out_bus.valid),
    .out_ready        (out_bus.ready),
    .out_running_slot (out_bus.running_slot),
    .out_previous_slot(out_bus.previous_slot),
    .out_switched     (out_bus.switched),
    .out_create_status(out_bus.create_status),
    .out_created_slot (out_bus.created_slot),
    .out_no_ready     (out_bus.no_ready),
    .mismatch_count   (mismatch_count),
    .results_owed     (results_owed)
  );

  always #2 clk = ~clk;

  // Hard stop in case the handshake hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one command word after a random gap and hold it until accepted.
  // valid stays high into the next word when no gap is drawn.
  task automatic send_word(cmd_t cmd, logic [31:0] now, logic [31:0] secs);
    int gap;
    if ($urandom_range(0, 39) == 0) feed_idle_on = !feed_idle_on;
    gap = feed_idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.command       <= cmd;
    in_bus.current_time  <= now;
    in_bus.sleep_seconds <= secs;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Stop feeding until every predicted result word has come back
  task automatic wait_results_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Result side: random stall before each word, with stretches of none
  initial begin : result_sink
    int stall;
    out_bus.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_idle_on = !sink_idle_on;
      stall = sink_idle_on ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
    end
  end

  initial begin : stimulus
    cmd_t        cmd;
    logic [31:0] wall_clock;
    logic [31:0] secs;
    int          roll;

    in_bus.valid         <= 1'b0;
    in_bus.command       <= CMD_SCHED;
    in_bus.current_time  <= '0;
    in_bus.sleep_seconds <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill the table, full create, wrap, wake all, exits down to nothing
    send_word(CMD_SCHED, 32'd0, 32'd0);                 // idle alone
    send_word(CMD_CREATE, 32'd5, 32'd0);                // append slot 1
    send_word(CMD_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // latest wake time
    send_word(CMD_CREATE, 32'd10, 32'hAAAA_AAAA);
    send_word(CMD_CREATE, 32'd11, 32'h5555_5555);       // table full
    send_word(CMD_SCHED, 32'd3, 32'd0);
    send_word(CMD_SLEEP, 32'd4, 32'd0);                 // sleep for zero seconds
    send_word(CMD_SLEEP, 32'd6, 32'hFFFF_FFFF);         // wake time wraps
    send_word(CMD_SCHED, 32'd7, 32'd0);
    send_word(CMD_SCHED, 32'hFFFF_FFFF, 32'd0);         // everything due
    send_word(CMD_EXIT, 32'd20, 32'd0);
    send_word(CMD_CREATE, 32'd21, 32'd0);               // reuse a dead slot
    send_word(CMD_SCHED, 32'd22, 32'd0);
    send_word(CMD_SLEEP, 32'd23, 32'h8000_0000);
    send_word(CMD_SLEEP, 32'd24, 32'h7FFF_FFFF);
    send_word(CMD_SLEEP, 32'd25, 32'hFFFF_FFF0);
    send_word(CMD_SLEEP, 32'd26, 32'h0000_FFFF);
    send_word(CMD_SCHED, 32'd27, 32'd0);                // likely nothing eligible
    send_word(CMD_EXIT, 32'd28, 32'd0);
    send_word(CMD_EXIT, 32'hFFFF_FFFF, 32'd0);
    send_word(CMD_EXIT, 32'hFFFF_FFFF, 32'd0);
    send_word(CMD_EXIT, 32'hFFFF_FFFF, 32'd0);          // all slots dead
    send_word(CMD_SCHED, 32'd30, 32'd0);
    send_word(CMD_CREATE, 32'd31, 32'd0);               // may land on the dead running slot
    send_word(CMD_SCHED, 32'd32, 32'd0);
    wait_results_drained();

    // Random: mostly creep time forward with short sleeps, sometimes jump or wrap
    wall_clock = 32'd40;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) cmd = CMD_SCHED;
      else if (roll < 60) cmd = CMD_SLEEP;
      else if (roll < 75) cmd = CMD_EXIT;
      else cmd = CMD_CREATE;
      if ($urandom_range(0, 49) == 0) wall_clock = $urandom;
      else wall_clock = wall_clock + $urandom_range(0, 3);
      roll = $urandom_range(0, 9);
      if (roll < 8) secs = $urandom_range(0, 6);
      else if (roll == 8) secs = $urandom;
      else secs = 32'hFFFF_FFFF - $urandom_range(0, 5);
      send_word(cmd, wall_clock, secs);
      if (k % 300 == 299) wait_results_drained();
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hdl/rrs_pkg.sv
hdl/rrs_if.sv
hdl/rrs_datapath.sv
hdl/rrs_ctrl.sv
hdl/round_robin_task_scheduler.sv
hdl/rrs_checker.sv
tb/task_table_checker.sv
tb/tb_round_robin_task_scheduler.sv
